// ===== src/mer_pkg.sv =====
package mer_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int PixW     = 8;
  localparam int CfgDataW = 11;
  localparam int CfgAddrW = 2;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = CfgDataW;
  localparam int OcW      = $clog2(MaxWidth * MaxHeight);
  localparam int CntW     = OcW + 1;
  localparam int WinCols  = 2;
  localparam int FifoDepth = 2;
  localparam int LineW    = 2 * PixW;

  localparam int ResetThreshold = 2;
  localparam int ResetWidth     = 640;
  localparam int ResetHeight    = 480;

  typedef logic [PixW-1:0] pix_t;

  typedef enum logic [CfgAddrW-1:0] {
    CfgThreshold = 2'd0,
    CfgWidth     = 2'd1,
    CfgHeight    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

  typedef struct packed {
    pix_t bot;
    pix_t mid;
    pix_t top;
  } column_t;

  typedef struct packed {
    logic bot;
    logic mid;
    logic top;
  } bgflags_t;

  typedef struct packed {
    logic last;
    pix_t pixel;
  } out_item_t;

  function automatic logic is_bg(input pix_t p, input pix_t thr);
    return p <= thr;
  endfunction

  function automatic bgflags_t col_bg(input column_t c, input pix_t thr);
    bgflags_t f;
    f.top = is_bg(c.top, thr);
    f.mid = is_bg(c.mid, thr);
    f.bot = is_bg(c.bot, thr);
    return f;
  endfunction

  function automatic logic [CfgDataW-1:0] clamp_dim(input logic [CfgDataW-1:0] d,
                                                    input logic [CfgDataW-1:0] m);
    logic [CfgDataW-1:0] r;
    if (d == '0) begin
      r = CfgDataW'(1);
    end else if (d > m) begin
      r = m;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== src/mer_ram.sv =====
module mer_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/mer_cell.sv =====
module mer_cell import mer_pkg::*; (
  input  logic     clk_i,
  input  logic     shift_i,
  input  pix_t     thr_i,
  input  column_t  col_i,
  output column_t  col_o,
  output bgflags_t bg_o
);

  column_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
  assign bg_o  = col_bg(col_q, thr_i);

endmodule

// ===== src/mer_out_fifo.sv =====
module mer_out_fifo import mer_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output out_item_t item_o
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntFW = $clog2(FifoDepth + 1);

  out_item_t        mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntFW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntFW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntFW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/mask_erosion_3x3.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: pixel_in, tuser: command
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pixel_out, tlast: frame_end
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_addr_i: index, cfg_data_i: value
//
// One item per clock while s_axis_tready is high; results pass through the output queue.
// The line store is one RAM with registered read, addressed by the next column.
// Results wait in a two-entry queue; s_axis_tready drops only while both entries are full.
// Reset clears control state only; no clearing pass, the line store content is never
// used before it is written within a frame. Configuration is ready every cycle.
module mask_erosion_3x3 import mer_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic                s_axis_tuser,   // [0] command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // [7:0] pixel_out
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pix_t                thr_q, thr_d;
  logic [CfgDataW-1:0] w_q, w_d, h_q, h_d;
  logic [CntW-1:0]     total_q, total_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [OcW-1:0]      oc_q, oc_d;

  logic            accept, cfg_we, in_done, step, emit, last, col_wrap, full;
  pix_t            val;
  logic [LineW-1:0] ram_rdata, byp_q, line_rd, line_wr;
  logic            byp_hit_q;
  column_t         win [WinCols+1];
  bgflags_t        bg  [WinCols+1];
  logic            c0, top_ok, bot_ok, left_ok, right_ok, hit;
  pix_t            centre, res;
  out_item_t       push_item, pop_item;

  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i;
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_done       = (n_q >= total_q);
  assign step          = accept && !(s_axis_tuser == CmdFlush && !in_done);
  assign val           = in_done ? '0 : s_axis_tdata;
  assign emit          = (n_q > CntW'(w_q));
  assign last          = ((CntW'(oc_q) + CntW'(1)) >= total_q);
  assign col_wrap      = ((CfgDataW'(col_q) + CfgDataW'(1)) >= w_q);

  always_comb begin
    thr_d   = thr_q;
    w_d     = w_q;
    h_d     = h_q;
    total_d = total_q;
    col_d   = col_q;
    row_d   = row_q;
    n_d     = n_q;
    oc_d    = oc_q;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_addr_i))
        CfgThreshold: thr_d = cfg_data_i[PixW-1:0];
        CfgWidth: begin
          w_d     = clamp_dim(cfg_data_i, CfgDataW'(MaxWidth));
          total_d = CntW'(w_d) * CntW'(h_q);
          col_d   = '0;
          row_d   = '0;
          n_d     = '0;
          oc_d    = '0;
        end
        CfgHeight: begin
          h_d     = clamp_dim(cfg_data_i, CfgDataW'(MaxHeight));
          total_d = CntW'(w_q) * CntW'(h_d);
          col_d   = '0;
          row_d   = '0;
          n_d     = '0;
          oc_d    = '0;
        end
        default: ;
      endcase
    end else if (step) begin
      if (emit && last) begin
        col_d = '0;
        row_d = '0;
        n_d   = '0;
        oc_d  = '0;
      end else begin
        oc_d = oc_q + OcW'(emit);
        n_d  = n_q + CntW'(1);
        if (col_wrap) begin
          col_d = '0;
          row_d = row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= PixW'(ResetThreshold);
      w_q       <= CfgDataW'(ResetWidth);
      h_q       <= CfgDataW'(ResetHeight);
      total_q   <= CntW'(ResetWidth * ResetHeight);
      col_q     <= '0;
      row_q     <= '0;
      n_q       <= '0;
      oc_q      <= '0;
      byp_hit_q <= 1'b0;
    end else begin
      thr_q     <= thr_d;
      w_q       <= w_d;
      h_q       <= h_d;
      total_q   <= total_d;
      col_q     <= col_d;
      row_q     <= row_d;
      n_q       <= n_d;
      oc_q      <= oc_d;
      byp_hit_q <= step && (col_d == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byp_q <= line_wr;
    end
  end

  assign line_rd = byp_hit_q ? byp_q : ram_rdata;
  assign line_wr = {line_rd[PixW-1:0], val};

  mer_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (col_q),
    .wdata_i (line_wr),
    .raddr_i (col_d),
    .rdata_o (ram_rdata)
  );

  assign win[0].top = line_rd[LineW-1:PixW];
  assign win[0].mid = line_rd[PixW-1:0];
  assign win[0].bot = val;
  assign bg[0]      = col_bg(win[0], thr_q);

  for (genvar i = 0; i < WinCols; i++) begin : g_cell
    mer_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (step),
      .thr_i   (thr_q),
      .col_i   (win[i]),
      .col_o   (win[i+1]),
      .bg_o    (bg[i+1])
    );
  end

  assign c0       = (col_q == '0);
  assign centre   = win[1].mid;
  assign top_ok   = c0 ? (row_q != RowW'(2)) : (row_q != RowW'(1));
  assign bot_ok   = c0 ? (row_q <= h_q) : (row_q < h_q);
  assign left_ok  = c0 ? (w_q != CfgDataW'(1)) : (col_q != ColW'(1));
  assign right_ok = !c0;

  assign hit = (top_ok && (bg[1].top || (left_ok && bg[2].top) || (right_ok && bg[0].top)))
            || (left_ok && bg[2].mid) || (right_ok && bg[0].mid)
            || (bot_ok && (bg[1].bot || (left_ok && bg[2].bot) || (right_ok && bg[0].bot)));

  assign res = (!is_bg(centre, thr_q) && hit) ? '0 : centre;

  assign push_item.pixel = res;
  assign push_item.last  = last;

  mer_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && emit),
    .push_item_i (push_item),
    .pop_i       (m_axis_tready),
    .full_o      (full),
    .valid_o     (m_axis_tvalid),
    .item_o      (pop_item)
  );

  assign m_axis_tdata = pop_item.pixel;
  assign m_axis_tlast = pop_item.last;

endmodule

// ===== src/mer_checker.sv =====
module mer_checker import mer_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [PixW-1:0]     s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [PixW-1:0]     m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [CfgDataW-1:0] cfg_data_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("m_axis payload changed while stalled");

  // input stalls only behind waiting results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("s_axis stalled with no result waiting");

  // a result appears only after an input transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an input transaction");

endmodule

bind mask_erosion_3x3 mer_checker u_mer_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench import mer_pkg::*;;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 12;
  localparam int RandomItems  = 1600;
  localparam int CalmTail     = 1450;
  localparam int WideFrameCut = MaxWidth + 64;
  localparam int TallFrameCut = 64;
  localparam int PressureAt   = MaxWidth + 8;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 16;
  localparam int MaxReports   = 10;
  localparam int TimeLimitNs  = 10_000_000;

  localparam logic [CfgAddrW-1:0] CfgSpare = 2'd3;

  typedef enum logic {
    RowItem,
    RowReg
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cmd_e                cmd;
    pix_t                pixel;
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] value;
    logic                typed;
    out_item_t           result;
  } stim_row_t;

  localparam stim_row_t DirectedRows [34] = '{
    '{RowReg,  CmdPixel, 8'd0,   CfgWidth,     11'd1,     1'b0, '0},
    '{RowReg,  CmdPixel, 8'd0,   CfgHeight,    11'd1,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd200, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd77,  CfgThreshold, 11'd0,     1'b1, '{1'b1, 8'd200}},
    '{RowReg,  CmdPixel, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd255, CfgThreshold, 11'd0,     1'b1, '{1'b1, 8'd255}},
    '{RowReg,  CmdPixel, 8'd0,   CfgThreshold, 11'h7FF,   1'b0, '0},
    '{RowItem, CmdPixel, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b1, '{1'b1, 8'd0}},
    '{RowReg,  CmdPixel, 8'd0,   CfgSpare,     11'h7FF,   1'b0, '0},
    '{RowReg,  CmdPixel, 8'd0,   CfgWidth,     11'd3,     1'b0, '0},
    '{RowReg,  CmdPixel, 8'd0,   CfgHeight,    11'd3,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd90,  CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd91,  CfgThreshold, 11'd0,     1'b0, '0},
    '{RowReg,  CmdPixel, 8'd0,   CfgHeight,    11'd3,     1'b0, '0},
    '{RowReg,  CmdPixel, 8'd0,   CfgThreshold, 11'd2,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd2,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd255, CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdPixel, 8'd3,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0},
    '{RowItem, CmdFlush, 8'd0,   CfgThreshold, 11'd0,     1'b0, '0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  pix_t                s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  pix_t                m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  pix_t                thr_cfg;
  logic [CfgDataW-1:0] width_cfg;
  logic [CfgDataW-1:0] height_cfg;
  pix_t                older_line [MaxWidth];
  pix_t                newer_line [MaxWidth];
  logic [23:0]         upper_win;
  logic [23:0]         middle_win;
  logic [23:0]         lower_win;
  int                  col_pos;
  int                  row_pos;
  int                  out_pos;

  out_item_t           eroded_queue [$];
  int                  errors        = 0;
  int                  random_items  = 0;
  bit                  src_idle_en   = 1'b1;
  bit                  snk_idle_en   = 1'b1;
  bit                  hold_request  = 1'b0;
  bit                  pressure_done = 1'b0;

  mask_erosion_3x3 u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic int eff_dim(input logic [CfgDataW-1:0] d, input int m);
    if (d == '0) return 1;
    if (int'(d) > m) return m;
    return int'(d);
  endfunction

  function automatic void restart_frame();
    upper_win  = '0;
    middle_win = '0;
    lower_win  = '0;
    col_pos    = 0;
    row_pos    = 0;
    out_pos    = 0;
  endfunction

  // Window byte off + j holds column cc - 1 + j of each row.
  function automatic pix_t eroded_value(input int off, input int cr, input int cc,
                                        input int w, input int h);
    logic [23:0] rows [3];
    pix_t        centre;
    int          k;
    rows[0] = upper_win;
    rows[1] = middle_win;
    rows[2] = lower_win;
    centre  = rows[1][PixW*(off+1) +: PixW];
    if (centre <= thr_cfg) return centre;
    for (int dy = 0; dy < 3; dy++) begin
      if ((dy == 0 && cr == 0) || (dy == 2 && cr + 1 >= h)) continue;
      for (int dx = 0; dx < 3; dx++) begin
        k = off + dx;
        if ((dy == 1 && dx == 1) || (dx == 0 && cc == 0) || (dx == 2 && cc + 1 >= w) || k > 2)
          continue;
        if (rows[dy][PixW*k +: PixW] <= thr_cfg) return '0;
      end
    end
    return centre;
  endfunction

  function automatic logic advance_frame(input cmd_e cmd, input pix_t pixel,
                                         output out_item_t res);
    int   w;
    int   h;
    int   total;
    int   pos;
    pix_t fresh;
    pix_t up;
    pix_t mid;
    logic emit;
    w     = eff_dim(width_cfg, MaxWidth);
    h     = eff_dim(height_cfg, MaxHeight);
    total = w * h;
    pos   = row_pos * w + col_pos;
    emit  = pos >= w + 1;
    res   = '0;
    fresh = pixel;
    if (pos < total && cmd == CmdFlush) return 1'b0;
    if (pos >= total) fresh = '0;
    if (emit && col_pos == 0) res.pixel = eroded_value(1, row_pos - 2, w - 1, w, h);
    up                  = older_line[col_pos];
    mid                 = newer_line[col_pos];
    older_line[col_pos] = mid;
    newer_line[col_pos] = fresh;
    upper_win  = {up, upper_win[23:PixW]};
    middle_win = {mid, middle_win[23:PixW]};
    lower_win  = {fresh, lower_win[23:PixW]};
    if (emit && col_pos != 0) res.pixel = eroded_value(0, row_pos - 1, col_pos - 1, w, h);
    if (emit) begin
      res.last = out_pos + 1 >= total;
      out_pos++;
      if (res.last) begin
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
        return 1'b1;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    return emit;
  endfunction

  function automatic pix_t mask_pixel(input int fg_pct);
    if (thr_cfg != 8'hFF && $urandom_range(1, 100) <= fg_pct)
      return pix_t'($urandom_range(int'(thr_cfg) + 1, 255));
    return pix_t'($urandom_range(0, int'(thr_cfg)));
  endfunction

  task automatic send_item(input cmd_e cmd, input pix_t pixel, input logic typed,
                           input out_item_t typed_res);
    int        gap;
    out_item_t res;
    logic      produced;
    gap = (src_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    produced = advance_frame(cmd, pixel, res);
    if (typed) begin
      eroded_queue = {eroded_queue, typed_res};
    end else if (produced) begin
      eroded_queue = {eroded_queue, res};
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (eroded_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (addr)
      CfgThreshold: thr_cfg = value[PixW-1:0];
      CfgWidth: begin
        width_cfg = value;
        restart_frame();
      end
      CfgHeight: begin
        height_cfg = value;
        restart_frame();
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_frame(input logic [CfgDataW-1:0] thr, input logic [CfgDataW-1:0] w,
                               input logic [CfgDataW-1:0] h);
    settle();
    write_reg(CfgThreshold, thr);
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
  endtask

  task automatic stream_frame(input int cut, input int fg_pct);
    int total;
    total = eff_dim(width_cfg, MaxWidth) * eff_dim(height_cfg, MaxHeight);
    for (int n = 0; n < cut; n++) begin
      if (n < total) begin
        if ($urandom_range(0, 19) == 0) send_item(CmdFlush, pix_t'($urandom), 1'b0, '0);
        send_item(CmdPixel, mask_pixel(fg_pct), 1'b0, '0);
      end else begin
        send_item(cmd_e'($urandom_range(0, 1)), pix_t'($urandom), 1'b0, '0);
      end
      random_items++;
      if (!pressure_done && random_items >= PressureAt) begin
        pressure_done = 1'b1;
        hold_request  = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    int   frames;
    int   w;
    int   total;
    int   cut;
    int   pick;
    logic aborted;
    thr_cfg    = PixW'(ResetThreshold);
    width_cfg  = CfgDataW'(ResetWidth);
    height_cfg = CfgDataW'(ResetHeight);
    for (int i = 0; i < MaxWidth; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    restart_frame();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowReg) begin
        settle();
        write_reg(DirectedRows[i].addr, DirectedRows[i].value);
      end else begin
        send_item(DirectedRows[i].cmd, DirectedRows[i].pixel, DirectedRows[i].typed,
                  DirectedRows[i].result);
      end
    end

    program_frame(11'd0, 11'h7FF, 11'd0);
    stream_frame(WideFrameCut, 90);
    program_frame(11'($urandom), 11'd0, 11'h7FF);
    stream_frame(TallFrameCut, 80);

    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 5);
      program_frame(pick == 0 ? 11'd0 : pick == 1 ? 11'h0FF : 11'($urandom),
                    $urandom_range(0, 15) == 0 ? 11'd0 : 11'($urandom_range(1, 12)),
                    $urandom_range(0, 15) == 0 ? 11'd0 : 11'($urandom_range(1, 6)));
      src_idle_en = random_items < CalmTail && $urandom_range(0, 3) != 0;
      snk_idle_en = random_items < CalmTail && $urandom_range(0, 3) != 0;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        w       = eff_dim(width_cfg, MaxWidth);
        total   = w * eff_dim(height_cfg, MaxHeight);
        aborted = $urandom_range(0, 9) == 0;
        cut     = aborted ? $urandom_range(0, total + w) : total + w + 1;
        stream_frame(cut, $urandom_range(40, 100));
        if (aborted) break;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (eroded_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : sink
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    out_item_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (eroded_queue.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected transaction: pixel %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = eroded_queue.pop_front();
        if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.last) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                     $time, want.pixel, m_axis_tdata, want.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin : watchdog
    #(TimeLimitNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
